// ===== sv/vlcbp_pkg.sv =====
package vlcbp_pkg;

  typedef enum logic [1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_ENCODE = 2'd1,
    FUNC_END    = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  localparam int unsigned LEN_W      = 6;
  localparam int unsigned END_SYMBOL = 1;

endpackage

// ===== sv/vlcbp_ram.sv =====
module vlcbp_ram #(
  parameter int unsigned WIDTH = 38,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/variable_length_code_bit_packer.sv =====
// Packs variable-length codes into bytes, first code bit in bit 7. Load items
// write a code/length pair into a SYMBOL_COUNT-entry table held in one RAM with
// registered read; entries hold nothing until written and get no clearing pass.
// Encode items append the code of their byte; end items append the code of
// symbol 1, then emit the zero-padded pending byte marked last and restart the
// accumulator. An item is looked up in the cycle it is taken; with the read
// registered, it is then merged into the accumulator, and any bytes it yields
// go to the output register once that register is free. A new item is taken
// every cycle as long as each item yields at most one byte and out_ready is
// high; an item yielding k bytes (up to (MAX_CODE_BITS+15)/8, end included)
// holds the output register until it has drained them, one per ready cycle.
module variable_length_code_bit_packer
  import vlcbp_pkg::*;
#(
  parameter int unsigned SYMBOL_COUNT  = 256,
  parameter int unsigned MAX_CODE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_symbol,
  input  logic [31:0] in_code_bits,
  input  logic [5:0]  in_code_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_packed_byte,
  output logic        out_last
);

  localparam int unsigned AW       = $clog2(SYMBOL_COUNT);
  localparam int unsigned ENT_W    = MAX_CODE_BITS + LEN_W;
  localparam int unsigned NRES_MAX = (MAX_CODE_BITS + 15) / 8;
  localparam int unsigned W        = 8 * NRES_MAX;
  localparam int unsigned SH_W     = $clog2(W + 1);
  localparam int unsigned NR_W     = $clog2(NRES_MAX + 1);

  func_t in_func_t;
  logic  in_fire;
  logic  in_range;
  logic  wr_en;
  logic [LEN_W-1:0] sat_len;
  logic [AW-1:0]    rd_addr;
  logic [ENT_W-1:0] rd_data;

  logic  s1_valid_r, s1_valid_nxt;
  func_t s1_func_r;
  logic  s1_hit_r;
  logic  s1_fire;
  logic  is_end;

  logic [7:0] part_r, part_nxt;
  logic [2:0] fill_r, fill_nxt;

  logic [W-1:0]    buf_word_r, buf_word_nxt;
  logic [NR_W-1:0] buf_cnt_r, buf_cnt_nxt;
  logic            buf_last_r, buf_last_nxt;
  logic            buf_free;
  logic            out_fire;

  logic [LEN_W-1:0]         len_eff;
  logic [MAX_CODE_BITS-1:0] rd_code;
  logic [W-1:0]             code_ext;
  logic [W-1:0]             code_mask;
  logic [SH_W-1:0]          sh;
  logic [LEN_W-1:0]         sum;
  logic [NR_W-1:0]          nbytes;
  logic [NR_W-1:0]          nres;
  logic [W-1:0]             merged;
  logic [W-1:0]             rest;

  assign in_func_t = func_t'(in_func);
  assign in_fire   = in_valid && in_ready;
  assign in_range  = {1'b0, in_symbol} < 9'(SYMBOL_COUNT);
  assign sat_len   = (in_code_length > LEN_W'(MAX_CODE_BITS)) ?
                     LEN_W'(MAX_CODE_BITS) : in_code_length;
  assign wr_en     = in_fire && (in_func_t == FUNC_LOAD) && in_range;
  assign rd_addr   = (in_func_t == FUNC_END) ? AW'(END_SYMBOL) : in_symbol[AW-1:0];

  vlcbp_ram #(
    .WIDTH (ENT_W),
    .DEPTH (SYMBOL_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (in_symbol[AW-1:0]),
    .wdata ({sat_len, in_code_bits[MAX_CODE_BITS-1:0]}),
    .re    (in_fire),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // merge of looked-up code into the accumulator
  assign is_end    = (s1_func_r == FUNC_END);
  assign len_eff   = s1_hit_r ? rd_data[ENT_W-1 -: LEN_W] : '0;
  assign rd_code   = rd_data[MAX_CODE_BITS-1:0];
  assign code_ext  = W'(rd_code);
  assign code_mask = ~({W{1'b1}} << len_eff);
  assign sh        = SH_W'(W) - SH_W'(fill_r) - SH_W'(len_eff);
  assign sum       = LEN_W'(fill_r) + len_eff;
  assign nbytes    = NR_W'(sum >> 3);
  assign nres      = nbytes + NR_W'(is_end);
  assign merged    = {part_r, {(W-8){1'b0}}} | ((code_ext & code_mask) << sh);
  assign rest      = merged << {nbytes, 3'b000};

  assign buf_free  = (buf_cnt_r == '0) || ((buf_cnt_r == NR_W'(1)) && out_ready);
  assign s1_fire   = s1_valid_r && ((nres == '0) || buf_free);
  assign in_ready  = !s1_valid_r || s1_fire;

  assign out_valid       = (buf_cnt_r != '0);
  assign out_packed_byte = buf_word_r[W-1 -: 8];
  assign out_last        = buf_last_r && (buf_cnt_r == NR_W'(1));
  assign out_fire        = out_valid && out_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    part_nxt = part_r;
    fill_nxt = fill_r;
    if (s1_fire && is_end) begin
      part_nxt = '0;
      fill_nxt = '0;
    end else if (s1_fire && s1_hit_r) begin
      part_nxt = rest[W-1 -: 8];
      fill_nxt = sum[2:0];
    end
  end

  always_comb begin
    buf_word_nxt = buf_word_r;
    buf_cnt_nxt  = buf_cnt_r;
    buf_last_nxt = buf_last_r;
    if (s1_fire && (nres != '0)) begin
      buf_word_nxt = merged;
      buf_cnt_nxt  = nres;
      buf_last_nxt = is_end;
    end else if (out_fire) begin
      buf_word_nxt = buf_word_r << 8;
      buf_cnt_nxt  = buf_cnt_r - NR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_func_r  <= FUNC_NONE;
      s1_hit_r   <= 1'b0;
      part_r     <= '0;
      fill_r     <= '0;
      buf_cnt_r  <= '0;
      buf_last_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (in_fire) begin
        s1_func_r <= in_func_t;
        s1_hit_r  <= ((in_func_t == FUNC_ENCODE) && in_range) || (in_func_t == FUNC_END);
      end
      part_r     <= part_nxt;
      fill_r     <= fill_nxt;
      buf_cnt_r  <= buf_cnt_nxt;
      buf_last_r <= buf_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_word_r <= buf_word_nxt;
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench
  import vlcbp_pkg::*;
();

  localparam int unsigned MAX_CODE_BITS = 32;

  typedef struct {
    func_t             func;
    logic [7:0]        sym;
    logic [31:0]       code;
    logic [5:0]        len;
    int                n_typed;
    logic [0:4][8:0]   typed;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_func;
  logic [7:0]  in_symbol;
  logic [31:0] in_code_bits;
  logic [5:0]  in_code_length;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_packed_byte;
  logic        out_last;

  // packer state mirror
  logic [31:0] code_mem [256];
  logic [5:0]  len_mem [256];
  logic [7:0]  acc_byte;
  int          acc_fill;

  // expected bytes, {last, byte}
  logic [8:0]  exp_bytes [$];
  logic [8:0]  new_bytes [$];
  logic [8:0]  want;
  int          mismatches;

  // per-item typed expectation, -1 means use the predictor
  int              row_typed;
  logic [0:4][8:0] row_exp;

  bit          calm;
  bit          written [256];
  logic [7:0]  written_syms [$];
  dir_row_t    dir_rows [$];

  variable_length_code_bit_packer u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_symbol       (in_symbol),
    .in_code_bits    (in_code_bits),
    .in_code_length  (in_code_length),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_packed_byte (out_packed_byte),
    .out_last        (out_last)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic append_code(input logic [7:0] s);
    for (int i = int'(len_mem[s]) - 1; i >= 0; i--) begin
      acc_byte[7 - acc_fill] = code_mem[s][i];
      acc_fill++;
      if (acc_fill == 8) begin
        new_bytes.push_back({1'b0, acc_byte});
        acc_byte = '0;
        acc_fill = 0;
      end
    end
  endtask

  task automatic pack_item(input func_t f, input logic [7:0] s, input logic [31:0] c,
                           input logic [5:0] l);
    case (f)
      FUNC_LOAD: begin
        code_mem[s] = c;
        len_mem[s] = (l > MAX_CODE_BITS) ? 6'(MAX_CODE_BITS) : l;
      end
      FUNC_ENCODE: append_code(s);
      FUNC_END: begin
        append_code(8'(END_SYMBOL));
        new_bytes.push_back({1'b1, acc_byte});
        acc_byte = '0;
        acc_fill = 0;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      new_bytes.delete();
      pack_item(func_t'(in_func), in_symbol, in_code_bits, in_code_length);
      if (row_typed >= 0) begin
        for (int k = 0; k < row_typed; k++) exp_bytes.push_back(row_exp[k]);
      end else begin
        foreach (new_bytes[k]) exp_bytes.push_back(new_bytes[k]);
      end
    end
    if (rst_n && out_valid && out_ready) begin
      if (exp_bytes.size() == 0) begin
        $display("%0t: unexpected item, byte %02h last %0b", $time, out_packed_byte,
                 out_last);
        mismatches++;
      end else begin
        want = exp_bytes.pop_front();
        if (out_packed_byte !== want[7:0]) begin
          $display("%0t: packed_byte mismatch, expected %02h, got %02h", $time, want[7:0],
                   out_packed_byte);
          mismatches++;
        end
        if (out_last !== want[8]) begin
          $display("%0t: last mismatch, expected %0b, got %0b", $time, want[8], out_last);
          mismatches++;
        end
      end
    end
  end

  task automatic add_row(input func_t f, input logic [7:0] s, input logic [31:0] c,
                         input logic [5:0] l, input int n, input logic [0:4][8:0] e);
    dir_row_t r;
    r.func = f;
    r.sym = s;
    r.code = c;
    r.len = l;
    r.n_typed = n;
    r.typed = e;
    dir_rows.push_back(r);
  endtask

  task automatic send_item(input func_t f, input logic [7:0] s, input logic [31:0] c,
                           input logic [5:0] l, input int n, input logic [0:4][8:0] e);
    int gap;
    gap = calm ? 0 : int'($urandom_range(0, 13));
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_symbol <= s;
    in_code_bits <= c;
    in_code_length <= l;
    row_typed <= n;
    row_exp <= e;
    do @(posedge clk); while (!in_ready);
    if (f == FUNC_LOAD && !written[s]) begin
      written[s] = 1'b1;
      written_syms.push_back(s);
    end
  endtask

  // result side
  initial begin
    int hold;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      hold = calm ? 0 : int'($urandom_range(0, 13));
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int count;
    int r;
    int pick;
    func_t f;
    logic [7:0] s;
    logic [5:0] l;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = FUNC_NONE;
    in_symbol = '0;
    in_code_bits = '0;
    in_code_length = '0;
    row_typed = -1;
    row_exp = '0;
    mismatches = 0;
    calm = 1'b0;
    acc_byte = '0;
    acc_fill = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    add_row(FUNC_LOAD,   8'd1,   32'h0000_0003, 6'd2,  0, '0);
    add_row(FUNC_END,    8'd0,   32'h0,         6'd0,  1, {9'h1C0, {4{9'h000}}});
    add_row(FUNC_LOAD,   8'd0,   32'hFFFF_FFFF, 6'd32, 0, '0);
    add_row(FUNC_ENCODE, 8'd0,   32'h0,         6'd0,  4, {{4{9'h0FF}}, 9'h000});
    add_row(FUNC_LOAD,   8'd255, 32'h0000_0000, 6'd63, 0, '0);
    add_row(FUNC_ENCODE, 8'd255, 32'hFFFF_FFFF, 6'd63, 4, {5{9'h000}});
    add_row(FUNC_LOAD,   8'd2,   32'hAAAA_AA5A, 6'd8,  0, '0);
    add_row(FUNC_ENCODE, 8'd2,   32'h0,         6'd0,  1, {9'h05A, {4{9'h000}}});
    add_row(FUNC_LOAD,   8'd3,   32'h0001_2345, 6'd0,  0, '0);
    add_row(FUNC_ENCODE, 8'd3,   32'h0,         6'd0,  0, '0);
    add_row(FUNC_NONE,   8'h80,  32'h5555_5555, 6'd21, 0, '0);
    add_row(FUNC_LOAD,   8'd4,   32'hFFFF_FFF5, 6'd3,  0, '0);
    add_row(FUNC_ENCODE, 8'd4,   32'h0,         6'd0, -1, '0);
    add_row(FUNC_ENCODE, 8'd4,   32'h0,         6'd0, -1, '0);
    add_row(FUNC_ENCODE, 8'd4,   32'h0,         6'd0, -1, '0);
    add_row(FUNC_ENCODE, 8'd0,   32'h0,         6'd0, -1, '0);
    add_row(FUNC_END,    8'd7,   32'h0,         6'd0, -1, '0);
    add_row(FUNC_LOAD,   8'd5,   32'h0000_007F, 6'd7,  0, '0);
    add_row(FUNC_LOAD,   8'd1,   32'h8000_0001, 6'd40, 0, '0);
    add_row(FUNC_ENCODE, 8'd5,   32'h0,         6'd0,  0, '0);
    add_row(FUNC_END,    8'd0,   32'h0,         6'd0,  5,
            {9'h0FF, 9'h000, 9'h000, 9'h000, 9'h102});
    add_row(FUNC_LOAD,   8'd1,   32'h0,         6'd0,  0, '0);
    add_row(FUNC_END,    8'd0,   32'h0,         6'd0,  1, {9'h100, {4{9'h000}}});
    add_row(FUNC_LOAD,   8'd1,   32'h0000_0006, 6'd3,  0, '0);

    foreach (dir_rows[i])
      send_item(dir_rows[i].func, dir_rows[i].sym, dir_rows[i].code, dir_rows[i].len,
                dir_rows[i].n_typed, dir_rows[i].typed);

    count = 0;
    while (count < 250) begin
      if (count % 40 == 0) calm = ($urandom_range(0, 2) == 0);
      if (count == 125) begin
        @(negedge clk);
        in_valid <= 1'b0;
        while (exp_bytes.size() != 0) @(posedge clk);
      end
      r = int'($urandom_range(0, 99));
      s = 8'($urandom_range(0, 255));
      pick = int'($urandom_range(0, 99));
      if (pick < 75) l = 6'($urandom_range(1, 12));
      else if (pick < 90) l = 6'($urandom_range(13, 32));
      else l = 6'($urandom_range(0, 63));
      if (r < 18) begin
        f = FUNC_LOAD;
      end else if (r < 82) begin
        f = FUNC_ENCODE;
        s = written_syms[$urandom_range(0, written_syms.size() - 1)];
      end else if (r < 96) begin
        f = FUNC_END;
      end else begin
        f = FUNC_NONE;
      end
      send_item(f, s, $urandom, l, -1, '0);
      if (f != FUNC_NONE) count++;
    end
    calm = 1'b0;

    @(negedge clk);
    in_valid <= 1'b0;
    while (exp_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
